### rtl/twcs_pkg.sv
// Package: shared types and constants of the textured wall column stepper.
`default_nettype none

package twcs_pkg;

    // Command codes of the input transaction
    localparam logic CMD_SETUP = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    // Wall faces
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT_LOG2 = 2'd2;

    localparam logic [12:0] SCREEN_HEIGHT_RST   = 13'd480;
    localparam logic [10:0] TEX_WIDTH_RST       = 11'd64;
    localparam logic [3:0]  TEX_HEIGHT_LOG2_RST = 4'd6;

    // Largest usable texture height exponent
    localparam int TEX_LOG2_MAX = 10;

    typedef struct packed {
        logic        cmd;
        logic [11:0] column;
        logic [15:0] slice_height;
        logic [15:0] wall_x;
        logic        side;
        logic        step_positive;
        logic        ray_dir_x_positive;
        logic        ray_dir_y_negative;
    } item_t;

    typedef struct packed {
        logic [11:0] out_column;
        logic [11:0] out_row;
        logic [1:0]  face;
        logic [9:0]  texel_x;
        logic [9:0]  texel_y;
        logic        last_row;
    } pixel_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPAN,
        S_DIV,
        S_MUL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch a setup transaction
        logic row;       // accepted row transaction
        logic calc;      // span bounds, texel column product, divider init
        logic div_step;  // one quotient bit
        logic finish;    // start position, mirror, span goes active
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_blocked;  // pixel register full and stalled
        logic empty;        // span has no rows
        logic div_done;     // last quotient bit this cycle
    } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/twcs_ctrl.sv
// Controller: setup sequencing and input handshake.
`default_nettype none

module twcs_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic                  item_cmd,
    output logic                       item_stall,
    output twcs_pkg::ctrl_cmd_t        cmd,
    input  wire twcs_pkg::ctrl_status_t status
);

    twcs_pkg::state_t state_reg;
    twcs_pkg::state_t state_next;
    logic             accept;

    assign accept = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            twcs_pkg::S_IDLE:
            begin
                if (accept && item_cmd == twcs_pkg::CMD_SETUP)
                begin
                    state_next = twcs_pkg::S_SPAN;
                end
            end
            twcs_pkg::S_SPAN:
            begin
                state_next = status.empty ? twcs_pkg::S_IDLE : twcs_pkg::S_DIV;
            end
            twcs_pkg::S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = twcs_pkg::S_MUL;
                end
            end
            twcs_pkg::S_MUL:
            begin
                state_next = twcs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = twcs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall   = (state_reg != twcs_pkg::S_IDLE) ||
                       (item_cmd == twcs_pkg::CMD_ROW && status.out_blocked);
        cmd.load     = accept && item_cmd == twcs_pkg::CMD_SETUP;
        cmd.row      = accept && item_cmd == twcs_pkg::CMD_ROW;
        cmd.calc     = state_reg == twcs_pkg::S_SPAN;
        cmd.div_step = state_reg == twcs_pkg::S_DIV;
        cmd.finish   = state_reg == twcs_pkg::S_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twcs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_setup_enters_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == twcs_pkg::S_SPAN)
        else $error("setup transaction did not start the span calculation");

    a_empty_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twcs_pkg::S_SPAN && status.empty) |=> state_reg == twcs_pkg::S_IDLE)
        else $error("empty span did not return to idle");

    a_div_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twcs_pkg::S_DIV && status.div_done) |=> state_reg == twcs_pkg::S_MUL)
        else $error("divider finished without start position step");

endmodule

`default_nettype wire

### rtl/twcs_datapath.sv
// Datapath: config registers, span math, serial divider, row stepper, pixel register.
`default_nettype none

module twcs_datapath
#(
    parameter int FRAC_BITS = 16,
    parameter int ROW_BITS  = 12
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [twcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [twcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire twcs_pkg::item_t                   item,
    input  wire twcs_pkg::ctrl_cmd_t               cmd,
    output twcs_pkg::ctrl_status_t                 status,
    output twcs_pkg::pixel_t                       pixel,
    output logic                                   pixel_valid,
    input  wire logic                              pixel_stall
);

    // Signed width for span arithmetic: holds hs + lh with a sign bit
    localparam int HS_W   = ROW_BITS + 1;
    localparam int SPAN_W = ((HS_W > 16) ? HS_W : 16) + 2;
    // Quotient bits of 2^(L+FRAC_BITS) / h
    localparam int NUM_W  = FRAC_BITS + twcs_pkg::TEX_LOG2_MAX + 1;
    localparam int CNT_W  = $clog2(NUM_W);

    // Configuration
    logic [12:0] screen_height_reg, screen_height_next;
    logic [10:0] tex_width_reg, tex_width_next;
    logic [3:0]  tex_h_log2_reg, tex_h_log2_next;

    // Setup capture
    logic [SPAN_W-1:0] hs_reg, hs_next;
    logic [15:0]       lh_reg, lh_next;
    logic [15:0]       wx_reg, wx_next;
    logic [10:0]       tw_reg, tw_next;
    logic [3:0]        le_reg, le_next;
    logic              mirror_reg, mirror_next;
    logic [11:0]       column_reg, column_next;
    logic [1:0]        face_reg, face_next;

    // Span and texture state
    logic [ROW_BITS-1:0]      current_row_reg, current_row_next;
    logic [ROW_BITS-1:0]      span_end_reg, span_end_next;
    logic signed [SPAN_W-1:0] offset_reg, offset_next;
    logic [10:0]              tx_reg, tx_next;
    logic [9:0]               texel_x_reg, texel_x_next;
    logic [31:0]              tex_step_reg, tex_step_next;
    logic [31:0]              tex_position_reg, tex_position_next;
    logic                     span_active_reg, span_active_next;

    // Divider
    logic [15:0]      rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    // Output register
    twcs_pkg::pixel_t pixel_reg, pixel_next;
    logic             pixel_valid_reg, pixel_valid_next;

    // Combinational helpers
    logic [SPAN_W-1:0]        hs_cap;
    logic [3:0]               l_live;
    logic signed [SPAN_W-1:0] hs_s, lh_s, d_s, start_s, end_raw_s, end_s;
    logic                     empty;
    logic [26:0]              tx_prod;
    logic [CNT_W-1:0]         exp_pos;
    logic [16:0]              trial;
    logic                     q_bit;
    logic [63:0]              q_ext;
    logic [31:0]              step_sat;
    logic [31:0]              offset_ext;
    logic [31:0]              pos_prod;
    logic [ROW_BITS-1:0]      row_inc;
    logic                     last;
    logic [31:0]              mag, ip;
    logic [10:0]              y_mask;
    logic [31:0]              row_ext;

    assign hs_cap = (SPAN_W'(screen_height_reg) > (SPAN_W'(1) << ROW_BITS)) ?
                    (SPAN_W'(1) << ROW_BITS) : SPAN_W'(screen_height_reg);
    assign l_live = (tex_h_log2_reg > 4'(twcs_pkg::TEX_LOG2_MAX)) ?
                    4'(twcs_pkg::TEX_LOG2_MAX) : tex_h_log2_reg;

    // Span bounds
    assign hs_s      = signed'(hs_reg);
    assign lh_s      = signed'(SPAN_W'(lh_reg));
    assign d_s       = hs_s - lh_s;
    assign start_s   = (d_s > 0) ? (d_s >>> 1) : '0;
    assign end_raw_s = (hs_s + lh_s) >>> 1;
    assign end_s     = (end_raw_s >= hs_s) ? (hs_s - SPAN_W'(1)) : end_raw_s;
    assign empty     = (lh_reg == 16'd0) || (hs_reg == '0) || (start_s >= end_s);
    assign tx_prod   = 27'(wx_reg) * 27'(tw_reg);

    // Restoring division of a power of two by h, MSB first
    assign exp_pos  = CNT_W'(le_reg) + CNT_W'(FRAC_BITS);
    assign trial    = {rem_reg, (bit_cnt_reg == exp_pos)};
    assign q_bit    = trial >= {1'b0, lh_reg};
    assign q_ext    = 64'(quot_reg);
    assign step_sat = (q_ext[63:32] != 32'd0) ? 32'hFFFF_FFFF : q_ext[31:0];

    assign offset_ext = 32'(offset_reg);
    assign pos_prod   = offset_ext * step_sat;

    // Row stepping
    assign row_inc = current_row_reg + ROW_BITS'(1);
    assign last    = row_inc == span_end_reg;
    assign mag     = (~tex_position_reg + 32'd1) >> FRAC_BITS;
    assign ip      = tex_position_reg[31] ? (32'd0 - mag) : (tex_position_reg >> FRAC_BITS);
    assign y_mask  = (11'd1 << l_live) - 11'd1;
    assign row_ext = 32'(current_row_reg);

    always_comb
    begin
        screen_height_next = screen_height_reg;
        tex_width_next     = tex_width_reg;
        tex_h_log2_next    = tex_h_log2_reg;
        hs_next            = hs_reg;
        lh_next            = lh_reg;
        wx_next            = wx_reg;
        tw_next            = tw_reg;
        le_next            = le_reg;
        mirror_next        = mirror_reg;
        column_next        = column_reg;
        face_next          = face_reg;
        current_row_next   = current_row_reg;
        span_end_next      = span_end_reg;
        offset_next        = offset_reg;
        tx_next            = tx_reg;
        texel_x_next       = texel_x_reg;
        tex_step_next      = tex_step_reg;
        tex_position_next  = tex_position_reg;
        span_active_next   = span_active_reg;
        rem_next           = rem_reg;
        quot_next          = quot_reg;
        bit_cnt_next       = bit_cnt_reg;
        pixel_next         = pixel_reg;
        pixel_valid_next   = pixel_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                twcs_pkg::CFG_SCREEN_HEIGHT:   screen_height_next = cfg_data;
                twcs_pkg::CFG_TEX_WIDTH:       tex_width_next     = cfg_data[10:0];
                twcs_pkg::CFG_TEX_HEIGHT_LOG2: tex_h_log2_next    = cfg_data[3:0];
                default:                       ;
            endcase
        end

        if (pixel_valid_reg && !pixel_stall)
        begin
            pixel_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            hs_next          = hs_cap;
            lh_next          = item.slice_height;
            wx_next          = item.wall_x;
            tw_next          = tex_width_reg;
            le_next          = l_live;
            column_next      = item.column;
            mirror_next      = item.side ? item.ray_dir_y_negative : item.ray_dir_x_positive;
            if (item.side)
            begin
                face_next = item.step_positive ? twcs_pkg::FACE_SOUTH : twcs_pkg::FACE_NORTH;
            end
            else
            begin
                face_next = item.step_positive ? twcs_pkg::FACE_WEST : twcs_pkg::FACE_EAST;
            end
            span_active_next = 1'b0;
        end

        if (cmd.row && span_active_reg)
        begin
            pixel_next.out_column = column_reg;
            pixel_next.out_row    = row_ext[11:0];
            pixel_next.face       = face_reg;
            pixel_next.texel_x    = texel_x_reg;
            pixel_next.texel_y    = ip[9:0] & y_mask[9:0];
            pixel_next.last_row   = last;
            pixel_valid_next      = 1'b1;
            tex_position_next     = tex_position_reg + tex_step_reg;
            current_row_next      = row_inc;
            if (last)
            begin
                span_active_next = 1'b0;
            end
        end

        if (cmd.calc)
        begin
            current_row_next = start_s[ROW_BITS-1:0];
            span_end_next    = end_s[ROW_BITS-1:0];
            offset_next      = start_s - (hs_s >>> 1) + (lh_s >>> 1);
            tx_next          = tx_prod[26:16];
            rem_next         = 16'd0;
            quot_next        = '0;
            bit_cnt_next     = CNT_W'(NUM_W - 1);
        end

        if (cmd.div_step)
        begin
            rem_next     = q_bit ? 16'(trial - {1'b0, lh_reg}) : trial[15:0];
            quot_next    = {quot_reg[NUM_W-2:0], q_bit};
            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
        end

        if (cmd.finish)
        begin
            tex_step_next     = step_sat;
            tex_position_next = pos_prod;
            texel_x_next      = mirror_reg ? 10'(tw_reg - tx_reg - 11'd1) : tx_reg[9:0];
            span_active_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= twcs_pkg::SCREEN_HEIGHT_RST;
            tex_width_reg     <= twcs_pkg::TEX_WIDTH_RST;
            tex_h_log2_reg    <= twcs_pkg::TEX_HEIGHT_LOG2_RST;
            span_active_reg   <= 1'b0;
            pixel_valid_reg   <= 1'b0;
            current_row_reg   <= '0;
            span_end_reg      <= '0;
            tex_position_reg  <= 32'd0;
            tex_step_reg      <= 32'd0;
            texel_x_reg       <= 10'd0;
            face_reg          <= twcs_pkg::FACE_NORTH;
            column_reg        <= 12'd0;
            bit_cnt_reg       <= '0;
        end
        else
        begin
            screen_height_reg <= screen_height_next;
            tex_width_reg     <= tex_width_next;
            tex_h_log2_reg    <= tex_h_log2_next;
            span_active_reg   <= span_active_next;
            pixel_valid_reg   <= pixel_valid_next;
            current_row_reg   <= current_row_next;
            span_end_reg      <= span_end_next;
            tex_position_reg  <= tex_position_next;
            tex_step_reg      <= tex_step_next;
            texel_x_reg       <= texel_x_next;
            face_reg          <= face_next;
            column_reg        <= column_next;
            bit_cnt_reg       <= bit_cnt_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        hs_reg     <= hs_next;
        lh_reg     <= lh_next;
        wx_reg     <= wx_next;
        tw_reg     <= tw_next;
        le_reg     <= le_next;
        mirror_reg <= mirror_next;
        offset_reg <= offset_next;
        tx_reg     <= tx_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        pixel_reg  <= pixel_next;
    end

    assign status.out_blocked = pixel_valid_reg && pixel_stall;
    assign status.empty       = empty;
    assign status.div_done    = bit_cnt_reg == '0;
    assign pixel              = pixel_reg;
    assign pixel_valid        = pixel_valid_reg;

    a_finish_activates: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> span_active_reg)
        else $error("span not active after setup finished");

    a_last_row_ends_span: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row && span_active_reg && last) |=> (!span_active_reg && pixel_valid_reg))
        else $error("final row did not close the span");

    a_idle_row_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row && !span_active_reg && !pixel_valid_reg) |=> !pixel_valid_reg)
        else $error("pixel produced with no active span");

endmodule

`default_nettype wire

### rtl/textured_wall_column_stepper.sv
// Top level: textured wall column stepper, controller plus datapath.
//
//  channel  direction  handshake                 payload
//  item     in         item_valid / item_stall   twcs_pkg::item_t (setup or row command)
//  pixel    out        pixel_valid / pixel_stall twcs_pkg::pixel_t (one per drawn row)
//  config   in         cfg_we                    cfg_index, cfg_data (13 bits)
//
// Rows stream at one per cycle while the pixel register drains; a row with no
// active span is taken and yields no pixel. A setup runs capture, span bounds,
// the divider steps and the start position multiply; the input stalls for all
// but the capture. An empty span stops after the span bounds, skipping the
// divider and the multiply. Reset is asynchronous, active low, loads the
// config defaults and clears the span; rows wait on pixel_stall.
`default_nettype none

module textured_wall_column_stepper
#(
    parameter int FRAC_BITS = 16,
    parameter int ROW_BITS  = 12
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [twcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [twcs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire twcs_pkg::item_t                 item,
    output logic                                 pixel_valid,
    input  wire logic                            pixel_stall,
    output twcs_pkg::pixel_t                     pixel
);

    // Command and status between the two halves
    twcs_pkg::ctrl_cmd_t    cmd;
    twcs_pkg::ctrl_status_t status;

    // Sequencer: idle/row handling, span, divide, multiply
    twcs_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .cmd        (cmd),
        .status     (status)
    );

    // Registers, arithmetic and the pixel output register
    twcs_datapath
    #(
        .FRAC_BITS (FRAC_BITS),
        .ROW_BITS  (ROW_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item),
        .cmd         (cmd),
        .status      (status),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall)
    );

endmodule

`default_nettype wire

### bench/twcs_pixel_checker.sv
// Checker: predicts pixels of the wall column stepper and compares them with the DUT.
module twcs_pixel_checker
    import twcs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int ROW_BITS  = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  item_valid,
    input  wire logic                  item_stall,
    input  wire item_t                 item,
    input  wire logic                  pixel_valid,
    input  wire logic                  pixel_stall,
    input  wire pixel_t                pixel,
    output int                         mismatches,
    output int                         pixels_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow configuration
    logic [12:0] scr_h;
    logic [10:0] tex_w;
    logic [3:0]  tex_log2;

    // shadow column state
    logic                span_on;
    logic [ROW_BITS-1:0] row_now;
    logic [ROW_BITS-1:0] row_stop;
    logic [31:0]         v_pos;
    logic [31:0]         v_step;
    logic [9:0]          col_tx;
    logic [1:0]          col_face;
    logic [11:0]         col_id;

    pixel_t pending_pixels[$];

    task automatic report(input string why, input pixel_t want, input pixel_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%s: want col %0d row %0d face %0d tx %0d ty %0d last %0b,",
                      " got col %0d row %0d face %0d tx %0d ty %0d last %0b"},
                     why, want.out_column, want.out_row, want.face, want.texel_x,
                     want.texel_y, want.last_row, got.out_column, got.out_row, got.face,
                     got.texel_x, got.texel_y, got.last_row);
    endtask

    // Apply one command to the shadow state; a drawn row queues its pixel.
    task automatic predict_pixel(input item_t it);
        int                  hs;
        int                  lh;
        int                  diff;
        int                  start_row;
        int                  end_row;
        int                  offset;
        int                  lg;
        longint unsigned     quot;
        logic [31:0]         tx;
        logic [31:0]         mag;
        logic [31:0]         ipart;
        logic [31:0]         ymask;
        logic [ROW_BITS-1:0] next_row;
        pixel_t              px;
        lg = (tex_log2 > TEX_LOG2_MAX) ? TEX_LOG2_MAX : int'(tex_log2);
        ymask = (32'd1 << lg) - 32'd1;
        if (it.cmd == CMD_SETUP)
        begin
            hs = (scr_h > (1 << ROW_BITS)) ? (1 << ROW_BITS) : int'(scr_h);
            lh = int'(it.slice_height);
            col_id = it.column;
            if (it.side == 1'b0)
                col_face = it.step_positive ? FACE_WEST : FACE_EAST;
            else
                col_face = it.step_positive ? FACE_SOUTH : FACE_NORTH;
            tx = 32'((64'(it.wall_x) * 64'(tex_w)) >> 16);
            if ((!it.side && it.ray_dir_x_positive) || (it.side && it.ray_dir_y_negative))
                tx = 32'(tex_w) - tx - 32'd1;
            col_tx = tx[9:0];
            span_on = 1'b0;
            if (lh != 0 && hs != 0)
            begin
                diff = hs - lh;
                start_row = (diff > 0) ? diff / 2 : 0;
                end_row = (hs + lh) / 2;
                if (end_row >= hs)
                    end_row = hs - 1;
                if (start_row < end_row)
                begin
                    quot = (64'd1 << (lg + FRAC_BITS)) / 64'(lh);
                    if (quot > 64'hFFFF_FFFF)
                        quot = 64'hFFFF_FFFF;
                    v_step = quot[31:0];
                    offset = start_row - hs / 2 + lh / 2;
                    v_pos = 32'(longint'(offset) * longint'(quot));
                    row_now = start_row[ROW_BITS-1:0];
                    row_stop = end_row[ROW_BITS-1:0];
                    span_on = 1'b1;
                end
            end
        end
        else if (span_on)
        begin
            next_row = row_now + 1'b1;
            // integer part truncated toward zero
            if (v_pos[31])
            begin
                mag = (~v_pos + 32'd1) >> FRAC_BITS;
                ipart = 32'd0 - mag;
            end
            else
            begin
                ipart = v_pos >> FRAC_BITS;
            end
            px.out_column = col_id;
            px.out_row = 12'(row_now);
            px.face = col_face;
            px.texel_x = col_tx;
            px.texel_y = 10'(ipart & ymask);
            px.last_row = (next_row == row_stop);
            pending_pixels.push_back(px);
            v_pos = v_pos + v_step;
            row_now = next_row;
            if (px.last_row)
                span_on = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            scr_h = SCREEN_HEIGHT_RST;
            tex_w = TEX_WIDTH_RST;
            tex_log2 = TEX_HEIGHT_LOG2_RST;
            span_on = 1'b0;
            row_now = '0;
            row_stop = '0;
            v_pos = '0;
            v_step = '0;
            col_tx = '0;
            col_face = '0;
            col_id = '0;
            pending_pixels.delete();
            mismatches = 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    report("unexpected pixel", '0, pixel);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel.out_column != want.out_column || pixel.out_row != want.out_row
                        || pixel.face != want.face || pixel.texel_x != want.texel_x
                        || pixel.texel_y != want.texel_y || pixel.last_row != want.last_row)
                        report("pixel mismatch", want, pixel);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_HEIGHT:   scr_h = cfg_data[12:0];
                    CFG_TEX_WIDTH:       tex_w = cfg_data[10:0];
                    CFG_TEX_HEIGHT_LOG2: tex_log2 = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                predict_pixel(item);
        end
        pixels_owed = pending_pixels.size();
    end

endmodule

### bench/tb_textured_wall_column_stepper.sv
// Testbench top: stimulus and verdict for the textured wall column stepper.
module tb_textured_wall_column_stepper;
    timeunit 1ns;
    timeprecision 1ps;
    import twcs_pkg::*;

    // Cycles to let a setup finish after the last pixel has come out. A setup
    // emits nothing and stalls the input until it is done.
    localparam int SETTLE = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  pixel_valid;
    logic                  pixel_stall = 1'b0;
    pixel_t                pixel;

    int mismatches;
    int pixels_owed;

    bit idle_on = 1'b0;   // random gaps and pixel back-pressure enabled
    int cur_h = 480;      // screen height as last programmed
    int fed;              // transactions sent in the current phase

    textured_wall_column_stepper dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel      (pixel)
    );

    twcs_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel      (pixel),
        .mismatches (mismatches),
        .pixels_owed(pixels_owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pixel back-pressure: random stall bursts, only while idle_on is set, separated
    // by short open windows. Exactly one assignment per clock step.
    initial
    begin
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                pixel_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            pixel_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Fully random transaction of the given command; row commands ignore the
    // other fields, so those still get random bits.
    function automatic item_t rand_item(input logic kind);
        logic [63:0] bits;
        item_t       it;
        bits = {$urandom, $urandom};
        it = bits[$bits(item_t)-1:0];
        it.cmd = kind;
        return it;
    endfunction

    // dirs = {side, step_positive, ray_dir_x_positive, ray_dir_y_negative}
    function automatic item_t setup_item(input int col, input int lh, input int wx,
                                         input logic [3:0] dirs);
        item_t it;
        it.cmd = CMD_SETUP;
        it.column = 12'(col);
        it.slice_height = 16'(lh);
        it.wall_x = 16'(wx);
        {it.side, it.step_positive, it.ray_dir_x_positive, it.ray_dir_y_negative} = dirs;
        return it;
    endfunction

    // Rows a setup with slice height lh will draw on the current screen; only
    // used to size the row bursts so most spans run to their last row.
    function automatic int span_rows(input int sh, input int lh);
        int hs;
        int lo;
        int hi;
        hs = (sh > 4096) ? 4096 : sh;
        if (lh == 0 || hs == 0)
            return 0;
        lo = (hs > lh) ? (hs - lh) / 2 : 0;
        hi = (hs + lh) / 2;
        if (hi >= hs)
            hi = hs - 1;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // Mostly short slices, some tall ones, the odd full-range value, and the
    // edges around the screen height.
    function automatic int pick_height();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(1, 24);
            6, 7:             v = $urandom_range(25, 300);
            8:                v = $urandom_range(0, 65535);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = cur_h - 1;
                    3:       v = cur_h;
                    4:       v = cur_h + 1;
                    default: v = 65535;
                endcase
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    // Present one transaction and hold it until it is taken. An optional idle
    // burst goes in front; valid is never dropped and raised in the same step.
    task automatic push_item(input item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Stop sending, wait for every predicted pixel, then give an in-flight
    // setup time to finish.
    task automatic quiesce();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pixels_owed != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_config(input int sh, input int tw, input int tl);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data <= CFG_DATA_W'(sh);
        @(posedge clk);
        cfg_index <= CFG_TEX_WIDTH;
        cfg_data <= CFG_DATA_W'(tw);
        @(posedge clk);
        cfg_index <= CFG_TEX_HEIGHT_LOG2;
        cfg_data <= CFG_DATA_W'(tl);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_h = sh;
    endtask

    // One column: a setup then a burst of rows. Usually the whole span; now and
    // then a few rows past its end (no pixels) or a span cut short so the next
    // setup abandons it.
    task automatic draw_column(input int lh, input int row_cap);
        int n;
        int mode;
        n = span_rows(cur_h, lh);
        if (n > row_cap)
            n = row_cap;
        push_item(setup_item($urandom_range(0, 4095), lh, $urandom_range(0, 65535),
                             4'($urandom)));
        mode = $urandom_range(0, 9);
        if (mode == 0)
            n = n + $urandom_range(1, 2);
        else if (mode == 1 && n > 0)
            n = $urandom_range(0, n - 1);
        repeat (n) push_item(rand_item(CMD_ROW));
        fed += n + 1;
    endtask

    task automatic run_phase(input int sh, input int tw, input int tl, input int quota,
                             input bit idling);
        quiesce();
        load_config(sh, tw, tl);
        idle_on = idling;
        fed = 0;
        while (fed < quota)
            draw_column(pick_height(), 40);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset configuration (480 rows, 64 wide, 64 high).
        idle_on = 1'b1;
        push_item(rand_item(CMD_ROW));                      // row with no span
        push_item(setup_item(0, 0, 16'h1234, 4'b0000));     // zero height: empty
        push_item(rand_item(CMD_ROW));
        push_item(setup_item(4095, 2, 0, 4'b0000));         // east, two rows
        repeat (3) push_item(rand_item(CMD_ROW));           // third is past the end
        push_item(setup_item(1, 1, 65535, 4'b0110));        // west, mirrored
        push_item(rand_item(CMD_ROW));
        push_item(setup_item(2, 3, 32768, 4'b1001));        // north, mirrored, negative start
        repeat (2) push_item(rand_item(CMD_ROW));           // abandoned before last row
        push_item(setup_item(3, 65535, 1, 4'b1100));        // south, clipped to full screen
        repeat (2) push_item(rand_item(CMD_ROW));
        push_item(setup_item(4, 480, 65535, 4'b0010));      // east, mirrored by x dir
        push_item(rand_item(CMD_ROW));
        push_item(setup_item(5, 479, 0, 4'b1110));          // south, x dir has no effect
        push_item(rand_item(CMD_ROW));

        // Random phases across configurations, extremes included:
        // one row screen, largest sizes, oversize values that clamp or wrap,
        // zero screen height, a random setting, and a clean reset-like close.
        run_phase(480, 64, 6, 90, 1'b1);
        run_phase(1, 1, 0, 25, 1'b1);
        run_phase(4096, 1024, 10, 110, 1'b1);
        run_phase(8191, 2047, 15, 80, 1'b0);
        run_phase(0, 0, 0, 25, 1'b1);
        run_phase(2, 1000, 3, 50, 1'b1);
        run_phase($urandom_range(1, 600), $urandom_range(1, 1024), $urandom_range(0, 10),
                  120, 1'b1);
        run_phase(480, 64, 6, 100, 1'b0);

        quiesce();
        if (mismatches == 0)
            $display("tb_textured_wall_column_stepper: PASS");
        else
            $display("tb_textured_wall_column_stepper: FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("tb_textured_wall_column_stepper: FAIL");
        $finish;
    end

endmodule
